/* rtl/core/itrd_pkg.sv */
// shared types, constants and helpers for the radix digit converter
package itrd_pkg;

    localparam int BL_W        = 7;
    localparam int CHAR_W      = 8;
    localparam int MAG_W       = 32;
    localparam int STEP_BITS   = 4;
    localparam int DIV_STEPS   = MAG_W / STEP_BITS;
    localparam int STEP_CNT_W  = $clog2(DIV_STEPS);
    localparam int SEEN_W      = 128;

    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'd45;
    localparam logic [CHAR_W-1:0] CHAR_NONE  = 8'd0;
    localparam logic [CHAR_W-1:0] DIGIT_LO   = 8'd48;
    localparam logic [CHAR_W-1:0] DIGIT_HI   = 8'd57;
    localparam logic [CHAR_W-1:0] UPPER_LO   = 8'd65;
    localparam logic [CHAR_W-1:0] UPPER_HI   = 8'd90;
    localparam logic [CHAR_W-1:0] LOWER_LO   = 8'd97;
    localparam logic [CHAR_W-1:0] LOWER_HI   = 8'd122;

    typedef enum logic {
        OP_WRITE   = 1'b0,
        OP_CONVERT = 1'b1
    } t_opcode;

    typedef enum logic [1:0] {
        ST_OK           = 2'd0,
        ST_BAD_ALPHABET = 2'd1,
        ST_RANGE        = 2'd2
    } t_status;

    typedef struct packed {
        t_opcode            opcode;
        logic [5:0]         entry_index;
        logic [7:0]         entry_char;
        logic signed [63:0] value;
    } t_in;

    typedef struct packed {
        logic [7:0] out_char;
        t_status    status;
        logic       last;
    } t_out;

    typedef enum logic [2:0] {
        EM_NONE,
        EM_ERR_ALPHA,
        EM_ERR_RANGE,
        EM_SIGN,
        EM_CHAR
    } t_emit;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_DIV,
        S_STORE,
        S_SIGN,
        S_RD_DIG,
        S_RD_CHR,
        S_OUT_CHR
    } t_state;

    typedef struct packed {
        logic  wr_entry;
        logic  load;
        logic  chk_step;
        logic  div_step;
        logic  store;
        logic  rd_dig;
        logic  rd_chr;
        t_emit emit;
    } t_cmd;

    typedef struct packed {
        logic len_bad;
        logic chk_done;
        logic alpha_bad;
        logic range_bad;
        logic div_last;
        logic quot_zero;
        logic neg;
        logic emit_last;
    } t_stat;

    function automatic logic is_alnum(input logic [CHAR_W-1:0] c);
        is_alnum = (c >= DIGIT_LO && c <= DIGIT_HI) ||
                   (c >= UPPER_LO && c <= UPPER_HI) ||
                   (c >= LOWER_LO && c <= LOWER_HI);
    endfunction

endpackage

/* rtl/core/itrd_ctrl.sv */
// sequencer for alphabet check, digit division and character output
module itrd_ctrl
    import itrd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_start,
    input  t_opcode i_opcode,
    input  t_stat   i_stat,
    output t_cmd    o_cmd,
    output logic    o_busy
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.emit = EM_NONE;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    if (i_opcode == OP_WRITE) begin
                        o_cmd.wr_entry = 1'b1;
                    end else begin
                        o_cmd.load = 1'b1;
                        n_state    = S_CHECK;
                    end
                end
            end
            S_CHECK: begin
                if (i_stat.len_bad) begin
                    o_cmd.emit = EM_ERR_ALPHA;
                    n_state    = S_IDLE;
                end else if (i_stat.chk_done) begin
                    if (i_stat.alpha_bad) begin
                        o_cmd.emit = EM_ERR_ALPHA;
                        n_state    = S_IDLE;
                    end else if (i_stat.range_bad) begin
                        o_cmd.emit = EM_ERR_RANGE;
                        n_state    = S_IDLE;
                    end else begin
                        n_state = S_DIV;
                    end
                end else begin
                    o_cmd.chk_step = 1'b1;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_stat.div_last) begin
                    n_state = S_STORE;
                end
            end
            S_STORE: begin
                o_cmd.store = 1'b1;
                if (i_stat.quot_zero) begin
                    n_state = i_stat.neg ? S_SIGN : S_RD_DIG;
                end else begin
                    n_state = S_DIV;
                end
            end
            S_SIGN: begin
                o_cmd.emit = EM_SIGN;
                n_state    = S_RD_DIG;
            end
            S_RD_DIG: begin
                o_cmd.rd_dig = 1'b1;
                n_state      = S_RD_CHR;
            end
            S_RD_CHR: begin
                o_cmd.rd_chr = 1'b1;
                n_state      = S_OUT_CHR;
            end
            S_OUT_CHR: begin
                o_cmd.emit = EM_CHAR;
                n_state    = i_stat.emit_last ? S_IDLE : S_RD_DIG;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

/* rtl/core/itrd_dpath.sv */
// alphabet store, validity sweep, radix divider, digit store and result register
module itrd_dpath
    import itrd_pkg::*;
#(
    parameter int MAX_BASE   = 64,
    parameter int MAX_DIGITS = 32
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  t_in             i_item,
    input  t_cmd            i_cmd,
    input  logic            i_cfg_wr,
    input  logic [BL_W-1:0] i_cfg_data,
    output t_stat           o_stat,
    output logic            o_valid,
    output t_out            o_result
);

    localparam int AW  = $clog2(MAX_BASE);
    localparam int DAW = $clog2(MAX_DIGITS);
    localparam int NW  = $clog2(MAX_DIGITS + 1);

    logic [CHAR_W-1:0]     r_alpha [MAX_BASE];
    logic [CHAR_W-1:0]     r_alpha_q;
    logic [BL_W-1:0]       r_dig [MAX_DIGITS];
    logic [BL_W-1:0]       r_dig_q;

    logic [BL_W-1:0]       r_base_len;
    logic [BL_W-1:0]       r_idx;
    logic                  r_chk_v;
    logic                  r_bad;
    logic [SEEN_W-1:0]     r_seen;
    logic                  r_neg;
    logic                  r_range_bad;
    logic [MAG_W-1:0]      r_mag;
    logic [BL_W-1:0]       r_rem;
    logic [STEP_CNT_W-1:0] r_step;
    logic [NW-1:0]         r_n;
    logic                  r_out_valid;
    t_out                  r_out;

    logic [MAG_W-1:0]      n_mag;
    logic [BL_W-1:0]       n_rem;
    logic [BL_W:0]         div_trial;
    logic                  in_range;
    logic [MAG_W-1:0]      load_mag;

    // sign extension of bit 31 through bit 63 means the value fits 32 bits
    assign in_range = (&i_item.value[63:31]) | ~(|i_item.value[63:31]);
    assign load_mag = i_item.value[63] ? (~i_item.value[MAG_W-1:0] + MAG_W'(1))
                                       : i_item.value[MAG_W-1:0];

    // restoring division, several quotient bits per cycle
    always_comb begin
        n_rem     = r_rem;
        n_mag     = r_mag;
        div_trial = '0;
        for (int j = 0; j < STEP_BITS; j++) begin
            div_trial = {n_rem, n_mag[MAG_W-1]};
            n_mag     = {n_mag[MAG_W-2:0], 1'b0};
            if (div_trial >= {1'b0, r_base_len}) begin
                div_trial = div_trial - {1'b0, r_base_len};
                n_mag[0]  = 1'b1;
            end
            n_rem = div_trial[BL_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_entry && int'(i_item.entry_index) < MAX_BASE) begin
            r_alpha[AW'(i_item.entry_index)] <= i_item.entry_char;
        end
        if (i_cmd.chk_step) begin
            r_alpha_q <= r_alpha[AW'(r_idx)];
        end else if (i_cmd.rd_chr) begin
            r_alpha_q <= r_alpha[AW'(r_dig_q)];
        end
        if (i_cmd.store && int'(r_n) < MAX_DIGITS) begin
            r_dig[DAW'(r_n)] <= r_rem;
        end
        if (i_cmd.rd_dig) begin
            r_dig_q <= r_dig[DAW'(r_n - NW'(1))];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_len  <= '0;
            r_idx       <= '0;
            r_chk_v     <= 1'b0;
            r_bad       <= 1'b0;
            r_seen      <= '0;
            r_neg       <= 1'b0;
            r_range_bad <= 1'b0;
            r_mag       <= '0;
            r_rem       <= '0;
            r_step      <= '0;
            r_n         <= '0;
            r_out_valid <= 1'b0;
            r_out       <= '0;
        end else begin
            if (i_cfg_wr) begin
                r_base_len <= i_cfg_data;
            end
            if (i_cmd.load) begin
                r_idx       <= '0;
                r_chk_v     <= 1'b0;
                r_bad       <= 1'b0;
                r_seen      <= '0;
                r_neg       <= i_item.value[63];
                r_range_bad <= ~in_range;
                r_mag       <= load_mag;
                r_rem       <= '0;
                r_step      <= '0;
                r_n         <= '0;
            end
            if (i_cmd.chk_step) begin
                r_chk_v <= (r_idx < r_base_len);
                if (r_idx < r_base_len) begin
                    r_idx <= r_idx + BL_W'(1);
                end
                if (r_chk_v) begin
                    if (!is_alnum(r_alpha_q) || r_seen[r_alpha_q[6:0]]) begin
                        r_bad <= 1'b1;
                    end
                    r_seen[r_alpha_q[6:0]] <= 1'b1;
                end
            end
            if (i_cmd.div_step) begin
                r_rem  <= n_rem;
                r_mag  <= n_mag;
                r_step <= r_step + STEP_CNT_W'(1);
            end
            if (i_cmd.store) begin
                if (int'(r_n) < MAX_DIGITS) begin
                    r_n <= r_n + NW'(1);
                end
                r_rem  <= '0;
                r_step <= '0;
            end
            r_out_valid <= (i_cmd.emit != EM_NONE);
            case (i_cmd.emit)
                EM_ERR_ALPHA: begin
                    r_out.out_char <= CHAR_NONE;
                    r_out.status   <= ST_BAD_ALPHABET;
                    r_out.last     <= 1'b1;
                end
                EM_ERR_RANGE: begin
                    r_out.out_char <= CHAR_NONE;
                    r_out.status   <= ST_RANGE;
                    r_out.last     <= 1'b1;
                end
                EM_SIGN: begin
                    r_out.out_char <= CHAR_MINUS;
                    r_out.status   <= ST_OK;
                    r_out.last     <= 1'b0;
                end
                EM_CHAR: begin
                    r_out.out_char <= r_alpha_q;
                    r_out.status   <= ST_OK;
                    r_out.last     <= (r_n == NW'(1));
                    r_n            <= r_n - NW'(1);
                end
                default: begin
                    r_out <= r_out;
                end
            endcase
        end
    end

    assign o_stat.len_bad   = (r_base_len < BL_W'(2)) || (int'(r_base_len) > MAX_BASE);
    assign o_stat.chk_done  = (r_idx == r_base_len) && !r_chk_v;
    assign o_stat.alpha_bad = r_bad;
    assign o_stat.range_bad = r_range_bad;
    assign o_stat.div_last  = (r_step == STEP_CNT_W'(DIV_STEPS - 1));
    assign o_stat.quot_zero = (r_mag == '0);
    assign o_stat.neg       = r_neg;
    assign o_stat.emit_last = (r_n == NW'(1));

    assign o_valid  = r_out_valid;
    assign o_result = r_out;

endmodule

/* rtl/core/integer_to_radix_digits_core.sv */
// top level of the signed integer to radix digit string converter
//
//  channel   signals                                   direction  beat taken when
//  item      start, busy, i_item                       in         start && !busy
//  result    o_valid, o_result                         out        o_valid (one cycle)
//  config    i_cfg_valid, o_cfg_ready, i_cfg_data      in         i_cfg_valid && o_cfg_ready
//
// write item: busy stays low
// convert item: an alphabet sweep over the L entries (L = base length), then
//   the divider makes each digit, 4 quotient bits per cycle over 32 bits,
//   then each character from the two registered memory reads, with a '-' first if negative
// bad base length errors at once, others follow the sweep; sync reset clears all control
// the result beat cannot be held off; o_cfg_ready is high only while idle
module integer_to_radix_digits_core
    import itrd_pkg::*;
#(
    parameter int MAX_BASE   = 64,
    parameter int MAX_DIGITS = 32
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    input  t_in             i_item,
    output logic            busy,
    output logic            o_valid,
    output t_out            o_result,
    input  logic            i_cfg_valid,
    output logic            o_cfg_ready,
    input  logic [BL_W-1:0] i_cfg_data
);

    t_cmd  cmd;
    t_stat stat;
    logic  ctrl_busy;

    itrd_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_opcode (i_item.opcode),
        .i_stat   (stat),
        .o_cmd    (cmd),
        .o_busy   (ctrl_busy)
    );

    itrd_dpath #(
        .MAX_BASE   (MAX_BASE),
        .MAX_DIGITS (MAX_DIGITS)
    ) u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_item     (i_item),
        .i_cmd      (cmd),
        .i_cfg_wr   (i_cfg_valid && !ctrl_busy),
        .i_cfg_data (i_cfg_data),
        .o_stat     (stat),
        .o_valid    (o_valid),
        .o_result   (o_result)
    );

    assign busy        = ctrl_busy;
    assign o_cfg_ready = !ctrl_busy;

endmodule

/* bench/itrd_char_checker.sv */
// scoreboard for the radix digit converter: predicts every conversion and checks each result beat
module itrd_char_checker
    import itrd_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  logic            i_busy,
    input  t_in             i_item,
    input  logic            i_valid,
    input  t_out            i_result,
    input  logic            i_cfg_valid,
    input  logic            i_cfg_ready,
    input  logic [BL_W-1:0] i_cfg_data,
    output int              o_fail_count,
    output int              o_pending,
    output int              o_char_count,
    output int              o_error_count
);

    logic [CHAR_W-1:0] alphabet [64];
    logic [BL_W-1:0]   radix_len;
    t_out              expected_text [$];
    int                fails  = 0;
    int                chars  = 0;
    int                errors = 0;

    function automatic bit is_digit_char(input logic [CHAR_W-1:0] c);
        return (c >= 8'd48 && c <= 8'd57) || (c >= 8'd65 && c <= 8'd90) ||
               (c >= 8'd97 && c <= 8'd122);
    endfunction

    function automatic bit alphabet_valid();
        int i;
        int k;
        if (radix_len < 2 || radix_len > 64)
            return 1'b0;
        for (i = 0; i < radix_len; i++) begin
            if (!is_digit_char(alphabet[i]))
                return 1'b0;
            for (k = i + 1; k < radix_len; k++)
                if (alphabet[i] == alphabet[k])
                    return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic void push_char(input logic [7:0] c, input t_status s, input logic l);
        t_out r;
        r.out_char = c;
        r.status   = s;
        r.last     = l;
        expected_text.push_back(r);
    endfunction

    task automatic predict_convert(input logic signed [63:0] v);
        logic [63:0] mag;
        logic [5:0]  digits [32];
        int          n;
        int          i;
        bit          neg;
        if (!alphabet_valid()) begin
            push_char(CHAR_NONE, ST_BAD_ALPHABET, 1'b1);
            return;
        end
        neg = v[63];
        mag = v;
        if (neg)
            mag = ~mag + 64'd1;
        if ((neg && mag > 64'd2147483648) || (!neg && mag > 64'd2147483647)) begin
            push_char(CHAR_NONE, ST_RANGE, 1'b1);
            return;
        end
        n = 0;
        if (mag == 64'd0) begin
            digits[0] = '0;
            n = 1;
        end else begin
            while (mag != 64'd0) begin
                digits[n] = 6'(mag % 64'(radix_len));
                mag = mag / 64'(radix_len);
                n++;
            end
        end
        if (neg)
            push_char(CHAR_MINUS, ST_OK, 1'b0);
        for (i = n - 1; i >= 0; i--)
            push_char(alphabet[digits[i]], ST_OK, i == 0);
    endtask

    always @(posedge i_clk) begin
        t_out want;
        if (!i_rst_n) begin
            radix_len = '0;
            expected_text.delete();
        end else begin
            if (i_valid) begin
                if (expected_text.size() == 0) begin
                    $error("result beat with nothing expected: out_char %0d status %0d last %0d",
                           i_result.out_char, i_result.status, i_result.last);
                    fails++;
                end else begin
                    want = expected_text.pop_front();
                    if (i_result.out_char !== want.out_char) begin
                        $error("out_char: expected %0d, got %0d", want.out_char, i_result.out_char);
                        fails++;
                    end
                    if (i_result.status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, i_result.status);
                        fails++;
                    end
                    if (i_result.last !== want.last) begin
                        $error("last: expected %0d, got %0d", want.last, i_result.last);
                        fails++;
                    end
                end
                if (i_result.status == ST_OK)
                    chars++;
                else
                    errors++;
            end
            if (i_cfg_valid && i_cfg_ready)
                radix_len = i_cfg_data;
            if (i_start && !i_busy) begin
                if (i_item.opcode == OP_WRITE)
                    alphabet[i_item.entry_index] = i_item.entry_char;
                else
                    predict_convert(i_item.value);
            end
        end
        o_pending     <= expected_text.size();
        o_fail_count  <= fails;
        o_char_count  <= chars;
        o_error_count <= errors;
    end

endmodule

/* bench/integer_to_radix_digits_core_tb.sv */
// testbench top for the radix digit converter: drives items and radix settings, gives the verdict
module integer_to_radix_digits_core_tb;
    import itrd_pkg::*;

    localparam int STALL_LIMIT = 4000;
    localparam int RANDOM_ITEMS = 130;

    logic            i_clk = 1'b0;
    logic            i_rst_n = 1'b0;
    logic            start = 1'b0;
    t_in             cmd_item = '0;
    logic            busy;
    logic            o_valid;
    t_out            o_result;
    logic            cfg_valid = 1'b0;
    logic            cfg_ready;
    logic [BL_W-1:0] cfg_data = '0;

    int fail_count;
    int pending;
    int char_count;
    int error_count;
    int quiet_cycles = 0;
    int items_sent = 0;
    int converts_sent = 0;
    int cfg_writes = 0;
    bit idling_on = 1'b0;
    int code_at [64];

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    integer_to_radix_digits_core u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .i_item      (cmd_item),
        .busy        (busy),
        .o_valid     (o_valid),
        .o_result    (o_result),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    itrd_char_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (start),
        .i_busy        (busy),
        .i_item        (cmd_item),
        .i_valid       (o_valid),
        .i_result      (o_result),
        .i_cfg_valid   (cfg_valid),
        .i_cfg_ready   (cfg_ready),
        .i_cfg_data    (cfg_data),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_char_count  (char_count),
        .o_error_count (error_count)
    );

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        while (quiet_cycles < STALL_LIMIT)
            @(posedge i_clk);
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic logic [7:0] code_char(input int k);
        if (k < 10)
            return 8'(48 + k);
        if (k < 36)
            return 8'(65 + k - 10);
        return 8'(97 + k - 36);
    endfunction

    task automatic rest();
        if (idling_on && $urandom_range(0, 3) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
    endtask

    task automatic issue(input t_in it);
        rest();
        cmd_item <= it;
        start    <= 1'b1;
        do @(posedge i_clk); while (busy);
        items_sent++;
    endtask

    task automatic write_entry(input int idx, input logic [7:0] c, input int code);
        t_in it;
        it.opcode      = OP_WRITE;
        it.entry_index = 6'(idx);
        it.entry_char  = c;
        it.value       = {$urandom, $urandom};
        code_at[idx]   = code;
        issue(it);
    endtask

    task automatic convert(input logic signed [63:0] v);
        t_in it;
        it.opcode      = OP_CONVERT;
        it.entry_index = 6'($urandom);
        it.entry_char  = 8'($urandom);
        it.value       = v;
        converts_sent++;
        issue(it);
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic set_radix(input int n);
        drain();
        cfg_data  <= BL_W'(n);
        cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        cfg_writes++;
    endtask

    // give entries below n distinct digit or letter codes
    task automatic repair(input int n);
        bit used [62];
        int i;
        int pick;
        for (i = 0; i < 62; i++)
            used[i] = 1'b0;
        for (i = 0; i < n; i++) begin
            if (code_at[i] < 0 || used[code_at[i]]) begin
                pick = $urandom_range(0, 61);
                while (used[pick])
                    pick = (pick + 1) % 62;
                write_entry(i, code_char(pick), pick);
            end
            used[code_at[i]] = 1'b1;
        end
    endtask

    task automatic swap_entries(input int n);
        int j;
        int k;
        int cj;
        int ck;
        j  = $urandom_range(0, n - 1);
        k  = $urandom_range(0, n - 1);
        cj = code_at[j];
        ck = code_at[k];
        if (cj >= 0 && ck >= 0) begin
            write_entry(j, code_char(ck), ck);
            write_entry(k, code_char(cj), cj);
        end else begin
            cj = $urandom_range(0, 61);
            write_entry(j, code_char(cj), cj);
        end
    endtask

    function automatic logic signed [63:0] pick_value();
        logic signed [63:0] v;
        logic [31:0]        w;
        int                 off;
        w   = $urandom;
        off = int'($urandom_range(0, 2)) - 1;
        case ($urandom_range(0, 9))
            0: v = '0;
            1, 2: begin
                v = 64'($urandom_range(0, 100));
                if ($urandom_range(0, 1))
                    v = -v;
            end
            3, 4, 5: v = {{32{w[31]}}, w};
            6: case ($urandom_range(0, 3))
                0: v = 64'sd2147483647;
                1: v = -64'sd2147483648;
                2: v = 64'sd2147483648;
                default: v = -64'sd2147483649;
            endcase
            7, 8: v = {$urandom, w};
            default: v = ($urandom_range(0, 1) ? 64'sd2147483647 : -64'sd2147483648) + off;
        endcase
        return v;
    endfunction

    initial begin
        int i;
        int radix_now;
        int base_count;
        int seg_len;
        int r;
        int lo;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // load digits, upper and lower case letters, then a sign and a duplicate
        for (i = 0; i < 62; i++)
            write_entry(i, code_char(i), i);
        write_entry(62, CHAR_MINUS, -1);
        write_entry(63, code_char(0), -1);

        convert(64'sd5);
        set_radix(1);
        convert(-64'sd7);

        set_radix(10);
        convert(64'sd0);
        convert(64'sd1);
        convert(-64'sd1);
        convert(64'sd2147483647);
        convert(-64'sd2147483648);
        convert(64'sd2147483648);
        convert(-64'sd2147483649);
        convert(64'h7fff_ffff_ffff_ffff);
        convert(64'h8000_0000_0000_0000);
        write_entry(3, code_char(1), -1);
        convert(64'sd42);
        convert(64'sd2147483648);
        write_entry(3, code_char(3), 3);
        write_entry(5, 8'h23, -1);
        convert(64'sd9);
        write_entry(5, code_char(5), 5);
        convert(-64'sd905);

        set_radix(2);
        convert(-64'sd2147483648);
        convert(64'sd2147483647);
        set_radix(62);
        convert(64'sd2147483647);
        convert(-64'sd12345);
        set_radix(64);
        convert(64'sd3);
        set_radix(65);
        convert(64'sd3);
        set_radix(127);
        convert(64'sd3);

        idling_on  = 1'b1;
        base_count = items_sent;
        while (items_sent - base_count < RANDOM_ITEMS) begin
            if (items_sent - base_count >= RANDOM_ITEMS - 40)
                idling_on = 1'b0;
            case ($urandom_range(0, 9))
                0: radix_now = $urandom_range(0, 1);
                1: radix_now = $urandom_range(63, 127);
                2: radix_now = 2;
                3: radix_now = 62;
                default: radix_now = $urandom_range(2, 62);
            endcase
            set_radix(radix_now);
            if (radix_now >= 2 && radix_now <= 62 && $urandom_range(0, 7) != 0)
                repair(radix_now);
            lo      = (radix_now >= 2 && radix_now <= 62) ? radix_now : 0;
            seg_len = $urandom_range(6, 16);
            for (i = 0; i < seg_len; i++) begin
                r = $urandom_range(0, 19);
                if (r < 14)
                    convert(pick_value());
                else if (r < 17 && lo != 0)
                    swap_entries(radix_now);
                else if (r < 19 && lo < 64)
                    write_entry($urandom_range(lo, 63), 8'($urandom), -1);
                else
                    write_entry($urandom_range(0, 63), 8'($urandom), -1);
            end
        end

        drain();
        repeat (40) @(posedge i_clk);
        $display("run covered %0d items (%0d conversions) under %0d radix settings",
                 items_sent, converts_sent, cfg_writes);
        $display("checked %0d character beats and %0d error beats", char_count, error_count);
        if (fail_count == 0 && pending == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

/* sim.f */
rtl/core/itrd_pkg.sv
rtl/core/itrd_ctrl.sv
rtl/core/itrd_dpath.sv
rtl/core/integer_to_radix_digits_core.sv
bench/itrd_char_checker.sv
bench/integer_to_radix_digits_core_tb.sv
